@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Boolean that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("%m: check failed");

// Property with implication, given in full by the caller
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

`endif

@@ rtl/core/cdq_pkg.sv @@
// Shared types and codes for the circular deque
package cdq_pkg;

  localparam int DataW  = 32;
  localparam int CmdW   = 2;
  localparam int StatW  = 2;
  localparam int MDataW = 40;  // data_out, is_empty, is_full, zero fill

  localparam logic [CmdW-1:0] CMD_PUSH_BACK  = 2'd0;
  localparam logic [CmdW-1:0] CMD_PUSH_FRONT = 2'd1;
  localparam logic [CmdW-1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [CmdW-1:0] CMD_POP_BACK   = 2'd3;

  localparam logic [StatW-1:0] ST_OK        = 2'd0;
  localparam logic [StatW-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [StatW-1:0] ST_UNDERFLOW = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;  // capture the input beat
    logic exec;  // apply the command to store and pointers
    logic emit;  // move the result into the output register
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

@@ rtl/core/circular_deque.sv @@
// Top level of the circular deque
//
// Input stream (s_*): one beat is one command. s_tuser carries the command
// (push back, push front, pop front, pop back), s_tdata the value to push,
// ignored on pops. Output stream (m_*): one beat per command. m_tuser is the
// status (ok, overflow, underflow); m_tdata holds the popped value (zero on
// pushes and failed pops) with the empty and full flags after the command.
//
// Timing: a command accepted at one edge is applied to the store in the next
// cycle and its result is loaded into the output register once that register
// is free. The sequencer handles one command at a time, through capture,
// store access (single port memory, registered read) and result load.
// A failed push or pop changes no state.
//
// Reset clears pointers, occupancy and the output valid; store contents are
// left as they were and never reach the output before being written.
// While m_tready is low the result is held; the next command is still taken
// and applied, then waits until the output register frees.
module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic signed [DataW-1:0] s_tdata,   // [31:0] data_in
  input  logic [CmdW-1:0]         s_tuser,   // [1:0] cmd
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [MDataW-1:0]       m_tdata,   // [31:0] data_out, [32] is_empty,
                                             // [33] is_full, [39:34] zero
  output logic [StatW-1:0]        m_tuser    // [1:0] status
);

  ctl_t ctl;
  sts_t sts;

  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  cdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

@@ rtl/core/cdq_ctrl.sv @@
// Command sequencer for the circular deque
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output ctl_t ctl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);
  assign ctl.load = (state == S_IDLE) && s_tvalid;
  assign ctl.exec = (state == S_EXEC);
  assign ctl.emit = (state == S_DONE) && sts.out_free;

endmodule

@@ rtl/core/cdq_dp.sv @@
// Store, pointers, occupancy and output register of the circular deque
module cdq_dp
  import cdq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ctl_t                    ctl,
  output sts_t                    sts,
  input  logic signed [DataW-1:0] s_tdata,
  input  logic [CmdW-1:0]         s_tuser,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [MDataW-1:0]       m_tdata,
  output logic [StatW-1:0]        m_tuser
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [DataW-1:0] mem [DEPTH];

  logic [CmdW-1:0]         cmd_q;
  logic signed [DataW-1:0] data_q;
  logic [AW-1:0]           head;
  logic [AW-1:0]           tail;
  logic [CW-1:0]           count;
  logic signed [DataW-1:0] rd_data;
  logic [StatW-1:0]        status_q;
  logic                    pop_q;

  logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec, addr;
  logic          is_push, full, empty, push_ok, pop_ok;
  logic signed [DataW-1:0] out_word;

  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign tail_inc = (tail == AW'(DEPTH - 1)) ? '0 : tail + AW'(1);
  assign tail_dec = (tail == '0) ? AW'(DEPTH - 1) : tail - AW'(1);

  assign is_push = (cmd_q == CMD_PUSH_BACK) || (cmd_q == CMD_PUSH_FRONT);
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = is_push && !full;
  assign pop_ok  = !is_push && !empty;

  always_comb begin
    case (cmd_q)
      CMD_PUSH_BACK:  addr = tail;
      CMD_PUSH_FRONT: addr = head_dec;
      CMD_POP_FRONT:  addr = head;
      CMD_POP_BACK:   addr = tail_dec;
      default:        addr = tail;
    endcase
  end

  // single port store, read data registered
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      if (push_ok) mem[addr] <= data_q;
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q  <= s_tuser;
      data_q <= s_tdata;
    end
    if (ctl.exec) begin
      pop_q <= pop_ok;
      if (is_push) status_q <= full ? ST_OVERFLOW : ST_OK;
      else         status_q <= empty ? ST_UNDERFLOW : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (ctl.exec) begin
      case (cmd_q)
        CMD_PUSH_BACK:  if (push_ok) tail <= tail_inc;
        CMD_PUSH_FRONT: if (push_ok) head <= head_dec;
        CMD_POP_FRONT:  if (pop_ok)  head <= head_inc;
        CMD_POP_BACK:   if (pop_ok)  tail <= tail_dec;
        default: ;
      endcase
      if (push_ok)     count <= count + CW'(1);
      else if (pop_ok) count <= count - CW'(1);
    end
  end

  assign out_word = pop_q ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // flags reflect the count already updated by the exec cycle
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      m_tuser <= status_q;
      m_tdata <= {6'b0, full, empty, out_word};
    end
  end

  assign sts.out_free = !m_tvalid || m_tready;

endmodule

@@ rtl/core/cdq_checker.sv @@
// Port-level checks for the circular deque, bound to the top level
`include "assert_macros.svh"

module cdq_checker
  import cdq_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    m_tvalid,
  input logic                    m_tready,
  input logic [MDataW-1:0]       m_tdata,
  input logic [StatW-1:0]        m_tuser
);

  // a stalled result beat holds
  `ASSERT_PROP(a_out_hold, clk, rst, (m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
  // never empty and full at once
  `ASSERT_ALWAYS(a_flags_excl, clk, rst, (!m_tvalid || !(m_tdata[32] && m_tdata[33])))
  // overflow only when full, with no data
  `ASSERT_PROP(a_ovf, clk, rst, (m_tvalid && m_tuser == ST_OVERFLOW |-> m_tdata[33] && m_tdata[31:0] == '0))
  // underflow only when empty, with no data
  `ASSERT_PROP(a_unf, clk, rst, (m_tvalid && m_tuser == ST_UNDERFLOW |-> m_tdata[32] && m_tdata[31:0] == '0))
  // status code and padding stay in range
  `ASSERT_ALWAYS(a_stat_code, clk, rst, (!m_tvalid || (m_tuser != 2'd3 && m_tdata[39:34] == '0)))

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);
